FILE: src/bcr_pkg.sv
package bcr_pkg;

  // angle units: 1/64 degree
  localparam int TURN_UNITS    = 23040;
  localparam int HALF_UNITS    = 11520;
  localparam int QUARTER_UNITS = 5760;

  // radians per angle unit, scaled by 2^38
  localparam logic [38:0] UNIT_TO_RAD_Q38 = 39'd74961321;

  localparam int ATAN_LEN = 24;
  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
    32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
    32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127
  };

  // perspective factor, Q16
  localparam int K_QBITS = 21;
  localparam int DIV_LAT = K_QBITS + 1;
  localparam logic [K_QBITS-1:0] K_MIN_Q16 = 21'd3277;
  localparam logic [K_QBITS-1:0] K_MAX_Q16 = 21'd1310720;

  // corner order TL, TR, BR, BL: which corners take the negative half size
  localparam logic [3:0] LX_NEG = 4'b1001;
  localparam logic [3:0] LY_NEG = 4'b0011;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic signed [23:0] box_x;
    logic signed [23:0] box_y;
    logic [22:0]        box_width;
    logic [22:0]        box_height;
    logic [22:0]        view_distance;
    logic signed [23:0] pan_x;
    logic signed [23:0] pan_y;
    logic signed [15:0] tilt_x_angle;
    logic signed [15:0] tilt_y_angle;
    logic signed [15:0] spin_angle;
  } bcr_in_t;

  typedef struct packed {
    logic signed [23:0] corner0_x;
    logic signed [23:0] corner0_y;
    logic signed [23:0] corner1_x;
    logic signed [23:0] corner1_y;
    logic signed [23:0] corner2_x;
    logic signed [23:0] corner2_y;
    logic signed [23:0] corner3_x;
    logic signed [23:0] corner3_y;
    logic               needs_quad;
  } bcr_out_t;

  typedef struct packed {
    logic signed [32:0] z;
    logic               sneg;
    logic               cneg;
  } bcr_ang_t;

  // classified word as it sits in the queue
  typedef struct packed {
    bcr_ang_t [2:0]     ang;
    logic [22:0]        bw;
    logic [22:0]        bh;
    logic [23:0]        dist_q9;
    logic               persp;
    logic               nq;
    logic signed [26:0] base_x;
    logic signed [26:0] base_y;
  } bcr_item_t;

  typedef struct packed {
    logic signed [25:0] x;
    logic signed [25:0] y;
  } bcr_pt_t;

  typedef struct packed {
    bcr_pt_t [3:0]      pt;
    logic               persp;
    logic               nq;
    logic signed [26:0] base_x;
    logic signed [26:0] base_y;
  } bcr_post_t;

endpackage

FILE: src/bcr_front.sv
module bcr_front import bcr_pkg::*; (
  input  bcr_in_t   in_data_i,
  output bcr_item_t item_o
);

  // wrap to one turn, fold into 0..90 degrees, convert to Q30 radians
  function automatic bcr_ang_t prep_angle(input logic signed [15:0] a);
    logic signed [16:0] r;
    logic [14:0]        u;
    logic [38:0]        p;
    bcr_ang_t           res;
    r = 17'(a);
    res.sneg = 1'b0;
    res.cneg = 1'b0;
    if (r < 17'sd0) begin
      r = r + 17'(TURN_UNITS);
      if (r < 17'sd0) begin
        r = r + 17'(TURN_UNITS);
      end
    end else if (r >= 17'(TURN_UNITS)) begin
      r = r - 17'(TURN_UNITS);
    end
    u = r[14:0];
    if (u > 15'(HALF_UNITS)) begin
      u = 15'(TURN_UNITS) - u;
      res.sneg = 1'b1;
    end
    if (u > 15'(QUARTER_UNITS)) begin
      u = 15'(HALF_UNITS) - u;
      res.cneg = 1'b1;
    end
    p = 39'(u) * UNIT_TO_RAD_Q38 + 39'd128;
    res.z = $signed({2'b00, p[38:8]});
    return res;
  endfunction

  always_comb begin
    item_o.ang[0]  = prep_angle(in_data_i.tilt_x_angle);
    item_o.ang[1]  = prep_angle(in_data_i.tilt_y_angle);
    item_o.ang[2]  = prep_angle(in_data_i.spin_angle);
    item_o.bw      = in_data_i.box_width;
    item_o.bh      = in_data_i.box_height;
    item_o.dist_q9 = {in_data_i.view_distance, 1'b0};
    item_o.persp   = in_data_i.view_distance >= 23'd3;
    item_o.nq      = (in_data_i.tilt_x_angle != 16'sd0) || (in_data_i.tilt_y_angle != 16'sd0)
                     || (in_data_i.spin_angle != 16'sd0);
    // centre minus scroll, Q9
    item_o.base_x = $signed({{2{in_data_i.box_x[23]}}, in_data_i.box_x, 1'b0})
                    + $signed({4'b0000, in_data_i.box_width})
                    - $signed({{2{in_data_i.pan_x[23]}}, in_data_i.pan_x, 1'b0});
    item_o.base_y = $signed({{2{in_data_i.box_y[23]}}, in_data_i.box_y, 1'b0})
                    + $signed({4'b0000, in_data_i.box_height})
                    - $signed({{2{in_data_i.pan_y[23]}}, in_data_i.pan_y, 1'b0});
  end

endmodule

FILE: src/bcr_queue.sv
module bcr_queue import bcr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  bcr_item_t wdata_i,
  input  logic      pop_i,
  output bcr_item_t rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  bcr_item_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

FILE: src/bcr_cordic.sv
module bcr_cordic import bcr_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [32:0] z_i,
  output logic signed [32:0] cos_o,
  output logic signed [32:0] sin_o
);

  localparam int N = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;

  logic signed [32:0] x_q [N];
  logic signed [32:0] y_q [N];
  logic signed [32:0] z_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [32:0] xp, yp, zp;
    logic signed [32:0] at;
    if (i == 0) begin : g_first
      assign xp = CORDIC_GAIN_Q30;
      assign yp = '0;
      assign zp = z_i;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
    end
    assign at = $signed({1'b0, ATAN_Q30[i]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (zp >= 33'sd0) begin
          x_q[i] <= xp - (yp >>> i);
          y_q[i] <= yp + (xp >>> i);
          z_q[i] <= zp - at;
        end else begin
          x_q[i] <= xp + (yp >>> i);
          y_q[i] <= yp - (xp >>> i);
          z_q[i] <= zp + at;
        end
      end
    end
  end

  assign cos_o = x_q[N-1];
  assign sin_o = y_q[N-1];

endmodule

FILE: src/bcr_div.sv
module bcr_div import bcr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [23:0]           dist_i,
  input  logic signed [27:0]    den_i,
  output logic [K_QBITS-1:0]    k_o
);

  // k = (dist * 65536 + den / 2) / den, one quotient bit per stage
  logic [47:0]        rem_q  [DIV_LAT];
  logic [K_QBITS-1:0] quo_q  [DIV_LAT];
  logic [26:0]        dd_q   [DIV_LAT];
  logic               neg_q  [DIV_LAT];
  logic               zero_q [DIV_LAT];
  logic               ovf_q  [DIV_LAT];

  logic [26:0] dd0;
  logic [47:0] num0;

  assign dd0  = den_i[26:0];
  assign num0 = {8'd0, dist_i, 16'd0} + {22'd0, dd0[26:1]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num0;
      quo_q[0]  <= '0;
      dd_q[0]   <= dd0;
      neg_q[0]  <= den_i < 28'sd0;
      zero_q[0] <= den_i == 28'sd0;
      ovf_q[0]  <= num0 >= {dd0, 21'd0};
    end
  end

  for (genvar j = 1; j < DIV_LAT; j++) begin : g_bit
    localparam int B = K_QBITS - j;
    logic [47:0] sub;
    assign sub = {21'd0, dd_q[j-1]} << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_q[j-1] >= sub) begin
          rem_q[j] <= rem_q[j-1] - sub;
          quo_q[j] <= quo_q[j-1] | (K_QBITS'(1) << B);
        end else begin
          rem_q[j] <= rem_q[j-1];
          quo_q[j] <= quo_q[j-1];
        end
        dd_q[j]   <= dd_q[j-1];
        neg_q[j]  <= neg_q[j-1];
        zero_q[j] <= zero_q[j-1];
        ovf_q[j]  <= ovf_q[j-1];
      end
    end
  end

  always_comb begin
    priority if (neg_q[DIV_LAT-1]) begin
      k_o = K_MIN_Q16;
    end else if (zero_q[DIV_LAT-1] || ovf_q[DIV_LAT-1]) begin
      k_o = K_MAX_Q16;
    end else if (quo_q[DIV_LAT-1] < K_MIN_Q16) begin
      k_o = K_MIN_Q16;
    end else if (quo_q[DIV_LAT-1] > K_MAX_Q16) begin
      k_o = K_MAX_Q16;
    end else begin
      k_o = quo_q[DIV_LAT-1];
    end
  end

endmodule

FILE: src/bcr_back.sv
module bcr_back import bcr_pkg::*; #(
  parameter int TRIG_STAGES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  bcr_item_t q_item_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output bcr_out_t  out_data_o
);

  localparam int NS = (TRIG_STAGES > ATAN_LEN) ? ATAN_LEN : TRIG_STAGES;
  localparam logic signed [58:0] HALF30 = 59'sd536870912;
  localparam logic signed [47:0] HALF16 = 48'sd32768;

  function automatic logic signed [24:0] side(input logic [22:0] m, input logic neg);
    logic signed [24:0] v;
    v = $signed({2'b00, m});
    return neg ? -v : v;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [32:0] v);
    logic signed [32:0] r;
    r = (v + 33'sd1) >>> 1;
    if (r > 33'sd8388607) begin
      return 24'sh7fffff;
    end else if (r < -33'sd8388608) begin
      return 24'sh800000;
    end
    return r[23:0];
  endfunction

  logic en;
  logic vf_q;

  assign en          = !(vf_q && out_stall_i);
  assign q_pop_o     = en && q_valid_i;
  assign out_valid_o = vf_q;

  // sine / cosine pipelines
  logic signed [32:0] cos_w [3];
  logic signed [32:0] sin_w [3];

  for (genvar a = 0; a < 3; a++) begin : g_trig
    bcr_cordic #(.STAGES(NS)) u_cordic (
      .clk_i (clk_i),
      .en_i  (en),
      .z_i   (q_item_i.ang[a].z),
      .cos_o (cos_w[a]),
      .sin_o (sin_w[a])
    );
  end

  bcr_item_t        line_q [NS];
  logic [NS-1:0]    lv_q;

  // stage registers
  logic signed [32:0] s_a_q [3], c_a_q [3], s_b_q [3], c_b_q [3], s_c_q [3], c_c_q [3];
  bcr_item_t          it_a_q, it_b_q, it_c_q, it_d_q;
  logic               va_q, vb_q, vc_q, vd_q, ve_q;
  logic signed [25:0] y1_b_q [4], z1_b_q [4], y1_c_q [4], x2_c_q [4], z2_c_q [4];
  logic signed [25:0] y1_d [4], z1_d [4], x2_d [4], z2_d [4], x3_d [4], y3_d [4];
  logic signed [27:0] den_d_q [4], den_d [4];
  bcr_post_t          post_d_q, post_d;
  bcr_post_t          post_q [DIV_LAT];
  logic [DIV_LAT-1:0] pv_q;
  logic [K_QBITS-1:0] k_w [4];
  logic signed [31:0] xs_e_q [4], ys_e_q [4], xs_d [4], ys_d [4];
  logic signed [26:0] bx_e_q, by_e_q;
  logic               nq_e_q;
  bcr_out_t           out_q, out_d;

  logic signed [57:0] pa [4], pb [4];
  logic signed [58:0] sa [4], sb [4], sc [4], sd [4];
  logic signed [47:0] mx [4], my [4];
  logic signed [24:0] lx, ly;

  // rotation about x
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ly       = side(it_a_q.bh, LY_NEG[i]);
      pa[i]    = ly * c_a_q[0];
      pb[i]    = ly * s_a_q[0];
      sa[i]    = (59'(pa[i]) + HALF30) >>> 30;
      sb[i]    = (59'(pb[i]) + HALF30) >>> 30;
      y1_d[i]  = sa[i][25:0];
      z1_d[i]  = sb[i][25:0];
    end
  end

  // rotation about y
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lx       = side(it_b_q.bw, LX_NEG[i]);
      sc[i]    = (59'(lx) * 59'(c_b_q[1]) + 59'(z1_b_q[i]) * 59'(s_b_q[1]) + HALF30) >>> 30;
      sd[i]    = (59'(z1_b_q[i]) * 59'(c_b_q[1]) - 59'(lx) * 59'(s_b_q[1]) + HALF30) >>> 30;
      x2_d[i]  = sc[i][25:0];
      z2_d[i]  = sd[i][25:0];
    end
  end

  // rotation about z, perspective denominator
  always_comb begin
    post_d.persp  = it_c_q.persp;
    post_d.nq     = it_c_q.nq;
    post_d.base_x = it_c_q.base_x;
    post_d.base_y = it_c_q.base_y;
    for (int i = 0; i < 4; i++) begin
      x3_d[i]        = 26'((59'(x2_c_q[i]) * 59'(c_c_q[2]) - 59'(y1_c_q[i]) * 59'(s_c_q[2])
                            + HALF30) >>> 30);
      y3_d[i]        = 26'((59'(x2_c_q[i]) * 59'(s_c_q[2]) + 59'(y1_c_q[i]) * 59'(c_c_q[2])
                            + HALF30) >>> 30);
      post_d.pt[i].x = x3_d[i];
      post_d.pt[i].y = y3_d[i];
      den_d[i]       = $signed({4'b0000, it_c_q.dist_q9}) - 28'(z2_c_q[i]);
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    bcr_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .dist_i (it_d_q.dist_q9),
      .den_i  (den_d_q[i]),
      .k_o    (k_w[i])
    );
  end

  // perspective scale
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mx[i] = post_q[DIV_LAT-1].pt[i].x * $signed({1'b0, k_w[i]});
      my[i] = post_q[DIV_LAT-1].pt[i].y * $signed({1'b0, k_w[i]});
      if (post_q[DIV_LAT-1].persp) begin
        xs_d[i] = 32'((mx[i] + HALF16) >>> 16);
        ys_d[i] = 32'((my[i] + HALF16) >>> 16);
      end else begin
        xs_d[i] = 32'(post_q[DIV_LAT-1].pt[i].x);
        ys_d[i] = 32'(post_q[DIV_LAT-1].pt[i].y);
      end
    end
  end

  // final offset, rounding to Q8, saturation
  always_comb begin
    out_d.corner0_x  = sat24(33'(bx_e_q) + 33'(xs_e_q[0]));
    out_d.corner0_y  = sat24(33'(by_e_q) + 33'(ys_e_q[0]));
    out_d.corner1_x  = sat24(33'(bx_e_q) + 33'(xs_e_q[1]));
    out_d.corner1_y  = sat24(33'(by_e_q) + 33'(ys_e_q[1]));
    out_d.corner2_x  = sat24(33'(bx_e_q) + 33'(xs_e_q[2]));
    out_d.corner2_y  = sat24(33'(by_e_q) + 33'(ys_e_q[2]));
    out_d.corner3_x  = sat24(33'(bx_e_q) + 33'(xs_e_q[3]));
    out_d.corner3_y  = sat24(33'(by_e_q) + 33'(ys_e_q[3]));
    out_d.needs_quad = nq_e_q;
    if (!nq_e_q) begin
      out_d = '0;
    end
  end

  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= '0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      pv_q <= '0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en) begin
      lv_q <= {lv_q[NS-2:0], q_pop_o};
      va_q <= lv_q[NS-1];
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      pv_q <= {pv_q[DIV_LAT-2:0], vd_q};
      ve_q <= pv_q[DIV_LAT-1];
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      line_q[0] <= q_item_i;
      for (int i = 1; i < NS; i++) begin
        line_q[i] <= line_q[i-1];
      end
      for (int a = 0; a < 3; a++) begin
        s_a_q[a] <= line_q[NS-1].ang[a].sneg ? -sin_w[a] : sin_w[a];
        c_a_q[a] <= line_q[NS-1].ang[a].cneg ? -cos_w[a] : cos_w[a];
        s_b_q[a] <= s_a_q[a];
        c_b_q[a] <= c_a_q[a];
        s_c_q[a] <= s_b_q[a];
        c_c_q[a] <= c_b_q[a];
      end
      it_a_q <= line_q[NS-1];
      it_b_q <= it_a_q;
      it_c_q <= it_b_q;
      it_d_q <= it_c_q;
      for (int i = 0; i < 4; i++) begin
        y1_b_q[i]  <= y1_d[i];
        z1_b_q[i]  <= z1_d[i];
        y1_c_q[i]  <= y1_b_q[i];
        x2_c_q[i]  <= x2_d[i];
        z2_c_q[i]  <= z2_d[i];
        den_d_q[i] <= den_d[i];
        xs_e_q[i]  <= xs_d[i];
        ys_e_q[i]  <= ys_d[i];
      end
      post_d_q  <= post_d;
      post_q[0] <= post_d_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        post_q[i] <= post_q[i-1];
      end
      bx_e_q <= post_q[DIV_LAT-1].base_x;
      by_e_q <= post_q[DIV_LAT-1].base_y;
      nq_e_q <= post_q[DIV_LAT-1].nq;
      out_q  <= out_d;
    end
  end

endmodule

FILE: src/box_corner_rotate_project.sv
// Box corner rotate and project. Each input word describes one box, its three
// rotation angles (1/64 degree, applied about X, then Y, then Z around the box
// centre), a perspective distance and a scroll offset; each output word holds
// the four projected corners TL, TR, BR, BL in saturated Q16.8 plus the
// needs_quad flag (all fields zero when every angle is zero). The block takes
// one word per clock while the queue is not full and returns one word per
// clock while the output is not stalled. A front stage wraps and folds the
// angles and computes the centre minus scroll, and parks the word in a
// four-entry queue. The back end is a single stall-together pipeline: three
// CORDIC units of TRIG_STAGES stages (at most 24), one register each for the
// sign fix and the three rotations, a 22-stage radix-2 divider per corner for
// the perspective factor, then one scale stage and the output register. The
// output register holds a finished word under stall while the queue keeps
// taking input until it is full.
module box_corner_rotate_project import bcr_pkg::*; #(
  parameter int TRIG_STAGES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bcr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bcr_out_t out_data_o
);

  bcr_item_t item_w;   // classified word from the front stage
  bcr_item_t head_w;   // oldest queued word
  logic      full_w;
  logic      empty_w;
  logic      pop_w;

  // angle wrap and fold, centre and scroll arithmetic
  bcr_front u_front (
    .in_data_i (in_data_i),
    .item_o    (item_w)
  );

  // decouples input acceptance from output stall
  assign in_stall_o = full_w;

  bcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i && !full_w),
    .wdata_i (item_w),
    .pop_i   (pop_w),
    .rdata_o (head_w),
    .full_o  (full_w),
    .empty_o (empty_w)
  );

  // trig, rotation, perspective divide and output register
  bcr_back #(.TRIG_STAGES(TRIG_STAGES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (!empty_w),
    .q_item_i    (head_w),
    .q_pop_o     (pop_w),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: dv/box_corner_rotate_project_tb.sv
`timescale 1ns / 100ps

module box_corner_rotate_project_tb import bcr_pkg::*;;

  localparam int STAGES     = 16;
  localparam int LATENCY    = STAGES + 30;
  localparam int IDLE_LIMIT = 20000;
  localparam longint OUT_MAX = 8388607;
  localparam longint OUT_MIN = -8388608;
  localparam longint GAIN    = 652032874;
  localparam longint K_LO    = 3277;
  localparam longint K_HI    = 1310720;

  // atan(2^-i) in Q30, rounded down
  localparam longint ARCTAN [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  // floor division by a power of two
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  // round half toward plus infinity
  function automatic longint rnd(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // sine and cosine in Q30 from an angle in 1/64 degree
  function automatic void trig(longint ang, output longint sn, output longint cs);
    longint r, x, y, z, dx, dy;
    bit sneg, cneg;
    r = ang % 23040;
    sneg = 0;
    cneg = 0;
    if (r < 0) r += 23040;
    if (r > 11520) begin
      r = 23040 - r;
      sneg = 1;
    end
    if (r > 5760) begin
      r = 11520 - r;
      cneg = 1;
    end
    z = rnd(r * 74961321, 8);
    x = GAIN;
    y = 0;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    sn = sneg ? -y : y;
    cs = cneg ? -x : x;
  endfunction

  // Q9 to saturated Q8
  function automatic logic signed [23:0] to_q8(longint q9);
    longint v;
    v = rnd(q9, 1);
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < OUT_MIN) v = OUT_MIN;
    return v[23:0];
  endfunction

  // projected corners of one box
  function automatic bcr_out_t project_box(bcr_in_t b);
    bcr_out_t r;
    longint sx, cxr, sy, cyr, sz, czr, cx, cy, dist_q9, lx, ly;
    longint y1, z1, x2, z2, x3, y3, den, k;
    logic signed [23:0] px [4];
    logic signed [23:0] py [4];
    r = '0;
    if (b.tilt_x_angle == 0 && b.tilt_y_angle == 0 && b.spin_angle == 0) return r;
    trig(longint'(b.tilt_x_angle), sx, cxr);
    trig(longint'(b.tilt_y_angle), sy, cyr);
    trig(longint'(b.spin_angle), sz, czr);
    cx = 2 * longint'(b.box_x) + longint'(b.box_width);
    cy = 2 * longint'(b.box_y) + longint'(b.box_height);
    dist_q9 = 2 * longint'(b.view_distance);
    for (int i = 0; i < 4; i++) begin
      lx = LX_NEG[i] ? -longint'(b.box_width) : longint'(b.box_width);
      ly = LY_NEG[i] ? -longint'(b.box_height) : longint'(b.box_height);
      y1 = rnd(ly * cxr, 30);
      z1 = rnd(ly * sx, 30);
      x2 = rnd(lx * cyr + z1 * sy, 30);
      z2 = rnd(z1 * cyr - lx * sy, 30);
      x3 = rnd(x2 * czr - y1 * sz, 30);
      y3 = rnd(x2 * sz + y1 * czr, 30);
      if (b.view_distance >= 3) begin
        den = dist_q9 - z2;
        if (den == 0) k = K_HI;
        else if (den < 0) k = K_LO;
        else begin
          k = (dist_q9 * 65536 + den / 2) / den;
          if (k < K_LO) k = K_LO;
          if (k > K_HI) k = K_HI;
        end
        x3 = rnd(x3 * k, 16);
        y3 = rnd(y3 * k, 16);
      end
      px[i] = to_q8(cx + x3 - 2 * longint'(b.pan_x));
      py[i] = to_q8(cy + y3 - 2 * longint'(b.pan_y));
    end
    r.corner0_x = px[0]; r.corner0_y = py[0];
    r.corner1_x = px[1]; r.corner1_y = py[1];
    r.corner2_x = px[2]; r.corner2_y = py[2];
    r.corner3_x = px[3]; r.corner3_y = py[3];
    r.needs_quad = 1'b1;
    return r;
  endfunction

  // expected corner words in order of acceptance
  class corner_board;
    bcr_out_t pending[$];
    int errors;

    function void note_box(bcr_in_t b);
      pending.push_back(project_box(b));
    endfunction

    function void report(string f, longint e, longint a);
      $display("%0t: %s expected %0d got %0d", $time, f, e, a);
      errors++;
    endfunction

    function void check_word(bcr_out_t got);
      bcr_out_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.corner0_x !== w.corner0_x) report("corner0_x", w.corner0_x, got.corner0_x);
      if (got.corner0_y !== w.corner0_y) report("corner0_y", w.corner0_y, got.corner0_y);
      if (got.corner1_x !== w.corner1_x) report("corner1_x", w.corner1_x, got.corner1_x);
      if (got.corner1_y !== w.corner1_y) report("corner1_y", w.corner1_y, got.corner1_y);
      if (got.corner2_x !== w.corner2_x) report("corner2_x", w.corner2_x, got.corner2_x);
      if (got.corner2_y !== w.corner2_y) report("corner2_y", w.corner2_y, got.corner2_y);
      if (got.corner3_x !== w.corner3_x) report("corner3_x", w.corner3_x, got.corner3_x);
      if (got.corner3_y !== w.corner3_y) report("corner3_y", w.corner3_y, got.corner3_y);
      if (got.needs_quad !== w.needs_quad) report("needs_quad", w.needs_quad, got.needs_quad);
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  bcr_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  bcr_out_t out_data_o;

  corner_board board = new();
  int idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  box_corner_rotate_project #(.TRIG_STAGES(STAGES)) dut (.*);

  // mostly short gaps, sometimes long, sometimes none at all
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(5))
      0: return 16'(int'($urandom_range(4)) - 2);
      1: return 16'($urandom_range(5760) - 2880);
      2: return 16'($urandom);
      3: return 16'(($urandom_range(8) - 4) * 5760);
      default: return 16'($urandom_range(1400) - 700);
    endcase
  endfunction

  function automatic bcr_in_t rand_box();
    bcr_in_t b;
    logic [223:0] raw;
    b = '0;
    if ($urandom_range(9) == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      b = raw[$bits(bcr_in_t)-1:0];
      return b;
    end
    b.box_x = 24'(int'($urandom_range(400000)) - 200000);
    b.box_y = 24'(int'($urandom_range(400000)) - 200000);
    b.box_width = 23'($urandom_range(100000));
    b.box_height = 23'($urandom_range(100000));
    case ($urandom_range(3))
      0: b.view_distance = 23'($urandom_range(2));
      1: b.view_distance = 23'($urandom_range(60000, 3));
      2: b.view_distance = 23'($urandom_range(200000));
      default: b.view_distance = 23'($urandom);
    endcase
    b.pan_x = 24'(int'($urandom_range(200000)) - 100000);
    b.pan_y = 24'(int'($urandom_range(200000)) - 100000);
    b.tilt_x_angle = rand_angle();
    b.tilt_y_angle = rand_angle();
    b.spin_angle = rand_angle();
    if ($urandom_range(19) == 0) begin
      b.tilt_x_angle = '0; b.tilt_y_angle = '0; b.spin_angle = '0;
    end
    return b;
  endfunction

  // hold one word on the input until it is taken
  task automatic send_box(bcr_in_t b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_directed();
    bcr_in_t b;
    b = '0;
    b.box_width = 23'd2560; b.box_height = 23'd1280; b.view_distance = 23'd256000;
    send_box(b); // no rotation
    b.tilt_x_angle = 16'sd1; send_box(b);
    b.tilt_x_angle = 16'sd0; b.spin_angle = 16'sd5760; send_box(b);
    b.spin_angle = 16'sd0; b.tilt_y_angle = -16'sd5760; send_box(b);
    b.tilt_y_angle = 16'sd32767; b.tilt_x_angle = 16'sh8000; b.spin_angle = 16'sd23040;
    send_box(b); // angles beyond one turn
    b.view_distance = 23'd2; send_box(b); // orthographic
    b.view_distance = 23'd3; send_box(b);
    // zero and negative denominators: box tilted 90 deg about y, depth equals d
    b = '0; b.box_width = 23'd1000; b.tilt_y_angle = 16'sd5760; b.view_distance = 23'd500;
    send_box(b);
    b.view_distance = 23'd100; send_box(b);
    b.tilt_y_angle = -16'sd5760; send_box(b);
    // saturation corners
    b = '1; b.box_x = 24'h7fffff; b.pan_x = 24'h800000; b.tilt_x_angle = 16'sd90;
    send_box(b);
    b.box_x = 24'h800000; b.box_y = 24'h800000; b.pan_x = 24'h7fffff;
    b.pan_y = 24'h7fffff; b.box_width = '0; b.box_height = '0; send_box(b);
    b = '1; send_box(b);
    b.view_distance = 23'h7fffff; b.tilt_y_angle = 16'sd2880; send_box(b);
    b = '0; b.spin_angle = -16'sd1; b.box_width = 23'h7fffff;
    b.box_height = 23'h7fffff; b.view_distance = 23'd3; send_box(b);
    b.tilt_x_angle = 16'sd11520; b.tilt_y_angle = 16'sd11520; send_box(b);
  endtask

  // note every accepted box and check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_box(in_data_i);
      if (out_valid_o && !out_stall_i) board.check_word(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls in bursts, with calm stretches
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_stall_i <= 1'b1;
        repeat (g) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
  end

  // watchdog on cycles with no traffic
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_directed();
    repeat (900) send_box(rand_box());
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/bcr_pkg.sv
src/bcr_front.sv
src/bcr_queue.sv
src/bcr_cordic.sv
src/bcr_div.sv
src/bcr_back.sv
src/box_corner_rotate_project.sv
dv/box_corner_rotate_project_tb.sv
